@@ hw/rtl/bus_voltage_correct_and_rectify_assert.svh @@
// assertion macros used by bvcr_skid
`ifndef BUS_VOLTAGE_CORRECT_AND_RECTIFY_ASSERT_SVH
`define BUS_VOLTAGE_CORRECT_AND_RECTIFY_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define BVCR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bvcr assertion failed");
// checked at every edge, reset included
`define BVCR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bvcr assertion failed");
`else
`define BVCR_ASSERT(label, clk, rst, prop)
`define BVCR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hw/rtl/bvcr_pkg.sv @@
package bvcr_pkg;

   localparam int VALUE_WIDTH_DEF   = 20;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam logic [1:0] KIND_REF = 2'd0;
   localparam logic [1:0] KIND_PV  = 2'd1;
   localparam logic [1:0] KIND_PQ  = 2'd2;

   // width of the reduction remainder and of the cordic angle, both q30 radians
   localparam int R_W = 36;
   localparam int Z_W = 34;

   localparam logic signed [R_W-1:0] PI_Q30       = 36'sd3373259426;
   localparam logic signed [R_W-1:0] TWO_PI_Q30   = 36'sd6746518852;
   localparam logic signed [R_W-1:0] THREE_PI_Q30 = 36'sd10119778278;
   localparam logic signed [R_W-1:0] HALF_PI_Q30  = 36'sd1686629713;
   localparam logic signed [R_W-1:0] NHALF_PI_Q30 = -36'sd1686629713;

   // q15 angle to q30
   localparam int ANG_TO_Q30 = 15;

   // about 2^48 / (2*pi*2^15), gives the turn count estimate
   localparam logic signed [31:0] ANG_RECIP   = 32'sd1367130551;
   localparam int                 RECIP_SHIFT = 48;

   // cordic gain in q30, start value is mag*gain/2^18 (q28)
   localparam logic signed [31:0] GAIN_Q30   = 32'sd652032875;
   localparam int                 GAIN_SHIFT = 18;

   // q28 to q16 with rounding
   localparam int OUT_SHIFT = 12;

   typedef struct packed {
      logic valid;
      logic neg;
   } ctl_type;

   function automatic logic [31:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'd843314857;
         1:  v = 32'd497837829;
         2:  v = 32'd263043837;
         3:  v = 32'd133525159;
         4:  v = 32'd67021687;
         5:  v = 32'd33543516;
         6:  v = 32'd16775851;
         7:  v = 32'd8388437;
         8:  v = 32'd4194282;
         9:  v = 32'd2097149;
         10: v = 32'd1048576;
         11: v = 32'd524288;
         12: v = 32'd262144;
         13: v = 32'd131072;
         14: v = 32'd65536;
         15: v = 32'd32768;
         16: v = 32'd16384;
         17: v = 32'd8192;
         18: v = 32'd4096;
         19: v = 32'd2048;
         20: v = 32'd1024;
         21: v = 32'd512;
         22: v = 32'd256;
         23: v = 32'd128;
         24: v = 32'd64;
         25: v = 32'd32;
         26: v = 32'd16;
         27: v = 32'd8;
         28: v = 32'd4;
         29: v = 32'd2;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/bus_voltage_correct_and_rectify.sv @@
// channel   direction  handshake             payload
// req_      in         req_tvalid/tready     tdata, tuser bus kind, tlast last bus
// rsp_      out        rsp_tvalid/tready     tdata, tlast last bus
//
// one transaction per cycle sustained while rsp_tready stays high; the pipeline is six
// correction and reduction stages, one per cordic rotation, rounding, output register
// reset clears every valid bit of the pipeline and the output stage
// a stalled output fills a spare slot; req_tready falls only while it is full
// and the whole pipeline holds, nothing dropped or repeated
module bus_voltage_correct_and_rectify #(
   parameter int VALUE_WIDTH   = bvcr_pkg::VALUE_WIDTH_DEF,
   parameter int CORDIC_STAGES = bvcr_pkg::CORDIC_STAGES_DEF,
   localparam int DATA_W       = ((4 * VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // mag_in, angle_in, angle_step, mag_step, zero fill
   input  logic [DATA_W-1:0] req_tdata,
   // bus_kind
   input  logic [1:0]        req_tuser,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // mag_out, angle_out, volt_real, volt_imag, zero fill
   output logic [DATA_W-1:0] rsp_tdata,
   output logic              rsp_tlast
);
   import bvcr_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int SW = 4 * W + 1;

   logic                  pipe_en;
   logic signed [W-1:0]   mag_in, angle_in, angle_step, mag_step;
   ctl_type               prep_ctl;
   logic                  prep_last;
   logic signed [W-1:0]   prep_mag, prep_ang;
   logic signed [W+13:0]  prep_x;
   logic signed [Z_W-1:0] prep_z;
   logic                  res_valid, res_last;
   logic signed [W-1:0]   res_mag, res_ang, res_re, res_im;
   logic [SW-1:0]         out_data;

   assign mag_in     = req_tdata[W-1:0];
   assign angle_in   = req_tdata[2*W-1:W];
   assign angle_step = req_tdata[3*W-1:2*W];
   assign mag_step   = req_tdata[4*W-1:3*W];
   assign req_tready = pipe_en;

   bvcr_prep #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_prep (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .in_valid(req_tvalid),
      .kind_i  (req_tuser),
      .mag_i   (mag_in),
      .ang_i   (angle_in),
      .dang_i  (angle_step),
      .dmag_i  (mag_step),
      .last_i  (req_tlast),
      .ctl_o   (prep_ctl),
      .last_o  (prep_last),
      .mag_o   (prep_mag),
      .ang_o   (prep_ang),
      .x_o     (prep_x),
      .z_o     (prep_z)
   );

   bvcr_cordic #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .en     (pipe_en),
      .ctl_i  (prep_ctl),
      .last_i (prep_last),
      .mag_i  (prep_mag),
      .ang_i  (prep_ang),
      .x_i    (prep_x),
      .z_i    (prep_z),
      .valid_o(res_valid),
      .last_o (res_last),
      .mag_o  (res_mag),
      .ang_o  (res_ang),
      .re_o   (res_re),
      .im_o   (res_im)
   );

   bvcr_skid #(
      .WIDTH(SW)
   ) u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  ({res_last, res_im, res_re, res_ang, res_mag}),
      .pipe_en  (pipe_en),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (out_data)
   );

   assign rsp_tdata = DATA_W'(out_data[4*W-1:0]);
   assign rsp_tlast = out_data[4*W];

endmodule

@@ hw/rtl/bvcr_prep.sv @@
module bvcr_prep #(
   parameter int VALUE_WIDTH = bvcr_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [1:0]                          kind_i,
   input  logic signed [VALUE_WIDTH-1:0]       mag_i,
   input  logic signed [VALUE_WIDTH-1:0]       ang_i,
   input  logic signed [VALUE_WIDTH-1:0]       dang_i,
   input  logic signed [VALUE_WIDTH-1:0]       dmag_i,
   input  logic                                last_i,
   output bvcr_pkg::ctl_type                   ctl_o,
   output logic                                last_o,
   output logic signed [VALUE_WIDTH-1:0]       mag_o,
   output logic signed [VALUE_WIDTH-1:0]       ang_o,
   output logic signed [VALUE_WIDTH+13:0]      x_o,
   output logic signed [bvcr_pkg::Z_W-1:0]     z_o
);
   import bvcr_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int XW = W + 14;
   localparam int PW = W + 36;
   localparam int MW = W + 32;
   localparam int RW = W + 24;
   localparam int QW = (W > 20) ? W - 16 : 4;

   localparam logic signed [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  VMIN = ~VMAX;
   localparam logic signed [PW-1:0] RND  = PW'(1) << (RECIP_SHIFT - 1);

   logic [5:0]                valid_ff;
   logic signed [W-1:0]       mag_ff [6];
   logic signed [W-1:0]       ang_ff [6];
   logic                      last_ff [6];
   logic signed [XW-1:0]      x_ff [5];
   logic signed [PW-1:0]      pq_ff;
   logic signed [RW-1:0]      qm_ff;
   logic signed [RW-1:0]      zp_ff;
   logic signed [R_W-1:0]     r_ff;
   logic signed [R_W-1:0]     zr_ff;
   logic signed [Z_W-1:0]     z_ff;
   logic                      neg_ff;

   logic signed [W:0]         ang_diff, mag_diff;
   logic signed [W-1:0]       ang_sat, mag_sat;
   logic signed [W-1:0]       mag1_in, ang1_in;
   logic signed [PW-1:0]      pq_in;
   logic signed [MW-1:0]      mp;
   logic signed [XW-1:0]      x2_in;
   logic signed [QW-1:0]      q_est;
   logic signed [RW-1:0]      qm_in, zp_in;
   logic signed [R_W-1:0]     r_in, zr_in;
   logic signed [Z_W-1:0]     z_in;
   logic                      neg_in;

   // stage 1: saturating corrections
   always_comb begin
      ang_diff = {ang_i[W-1], ang_i} - {dang_i[W-1], dang_i};
      mag_diff = {mag_i[W-1], mag_i} - {dmag_i[W-1], dmag_i};
      if (ang_diff[W] != ang_diff[W-1]) begin
         ang_sat = ang_diff[W] ? VMIN : VMAX;
      end else begin
         ang_sat = ang_diff[W-1:0];
      end
      if (mag_diff[W] != mag_diff[W-1]) begin
         mag_sat = mag_diff[W] ? VMIN : VMAX;
      end else begin
         mag_sat = mag_diff[W-1:0];
      end
      case (kind_i)
         KIND_PV: begin
            ang1_in = ang_sat;
            mag1_in = mag_i;
         end
         KIND_PQ: begin
            ang1_in = ang_sat;
            mag1_in = mag_sat;
         end
         default: begin
            ang1_in = ang_i;
            mag1_in = mag_i;
         end
      endcase
   end

   // stage 2: turn count estimate and cordic start value
   always_comb begin
      pq_in = PW'(ang_ff[0]) * PW'(ANG_RECIP) + RND;
      mp    = MW'(mag_ff[0]) * MW'(GAIN_Q30);
      x2_in = XW'(mp >>> GAIN_SHIFT);
   end

   // stage 3: turns times 2*pi, angle to q30 shifted by pi
   always_comb begin
      q_est = $signed(pq_ff[RECIP_SHIFT +: QW]);
      qm_in = RW'(q_est) * RW'(TWO_PI_Q30);
      zp_in = (RW'(ang_ff[1]) <<< ANG_TO_Q30) + RW'(PI_Q30);
   end

   // stage 4: remainder, off by at most one turn
   assign r_in = R_W'(zp_ff - qm_ff);

   // stage 5: fix the estimate and bring back to [-pi, pi)
   always_comb begin
      if (r_ff[R_W-1]) begin
         zr_in = r_ff + PI_Q30;
      end else if (r_ff >= TWO_PI_Q30) begin
         zr_in = r_ff - THREE_PI_Q30;
      end else begin
         zr_in = r_ff - PI_Q30;
      end
   end

   // stage 6: fold into [-pi/2, pi/2]
   always_comb begin
      if (zr_ff > HALF_PI_Q30) begin
         z_in   = Z_W'(zr_ff - PI_Q30);
         neg_in = 1'b1;
      end else if (zr_ff < NHALF_PI_Q30) begin
         z_in   = Z_W'(zr_ff + PI_Q30);
         neg_in = 1'b1;
      end else begin
         z_in   = Z_W'(zr_ff);
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff[0]  <= mag1_in;
         ang_ff[0]  <= ang1_in;
         last_ff[0] <= last_i;
         for (int k = 1; k < 6; k++) begin
            mag_ff[k]  <= mag_ff[k-1];
            ang_ff[k]  <= ang_ff[k-1];
            last_ff[k] <= last_ff[k-1];
         end
         x_ff[0] <= x2_in;
         for (int k = 1; k < 5; k++) begin
            x_ff[k] <= x_ff[k-1];
         end
         pq_ff  <= pq_in;
         qm_ff  <= qm_in;
         zp_ff  <= zp_in;
         r_ff   <= r_in;
         zr_ff  <= zr_in;
         z_ff   <= z_in;
         neg_ff <= neg_in;
      end
   end

   assign ctl_o  = '{valid: valid_ff[5], neg: neg_ff};
   assign last_o = last_ff[5];
   assign mag_o  = mag_ff[5];
   assign ang_o  = ang_ff[5];
   assign x_o    = x_ff[4];
   assign z_o    = z_ff;

endmodule

@@ hw/rtl/bvcr_cordic.sv @@
module bvcr_cordic #(
   parameter int VALUE_WIDTH   = bvcr_pkg::VALUE_WIDTH_DEF,
   parameter int CORDIC_STAGES = bvcr_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  bvcr_pkg::ctl_type                   ctl_i,
   input  logic                                last_i,
   input  logic signed [VALUE_WIDTH-1:0]       mag_i,
   input  logic signed [VALUE_WIDTH-1:0]       ang_i,
   input  logic signed [VALUE_WIDTH+13:0]      x_i,
   input  logic signed [bvcr_pkg::Z_W-1:0]     z_i,
   output logic                                valid_o,
   output logic                                last_o,
   output logic signed [VALUE_WIDTH-1:0]       mag_o,
   output logic signed [VALUE_WIDTH-1:0]       ang_o,
   output logic signed [VALUE_WIDTH-1:0]       re_o,
   output logic signed [VALUE_WIDTH-1:0]       im_o
);
   import bvcr_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int XW = W + 14;
   localparam int N  = CORDIC_STAGES;

   localparam logic signed [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  VMIN = ~VMAX;
   localparam logic signed [XW-1:0] RND  = XW'(1) << (OUT_SHIFT - 1);

   ctl_type               ctl_ff  [N];
   logic                  last_ff [N];
   logic signed [W-1:0]   mag_ff  [N];
   logic signed [W-1:0]   ang_ff  [N];
   logic signed [XW-1:0]  x_ff    [N];
   logic signed [XW-1:0]  y_ff    [N];
   logic signed [Z_W-1:0] z_ff    [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q30(i));

      ctl_type               ctl_cur;
      logic                  last_cur;
      logic signed [W-1:0]   mag_cur, ang_cur;
      logic signed [XW-1:0]  x_cur, y_cur, x_sh, y_sh, x_in, y_in;
      logic signed [Z_W-1:0] z_cur, z_in;

      if (i == 0) begin : g_first
         assign ctl_cur  = ctl_i;
         assign last_cur = last_i;
         assign mag_cur  = mag_i;
         assign ang_cur  = ang_i;
         assign x_cur    = x_i;
         assign y_cur    = '0;
         assign z_cur    = z_i;
      end else begin : g_next
         assign ctl_cur  = ctl_ff[i-1];
         assign last_cur = last_ff[i-1];
         assign mag_cur  = mag_ff[i-1];
         assign ang_cur  = ang_ff[i-1];
         assign x_cur    = x_ff[i-1];
         assign y_cur    = y_ff[i-1];
         assign z_cur    = z_ff[i-1];
      end

      assign x_sh = x_cur >>> i;
      assign y_sh = y_cur >>> i;

      // turn toward positive angle when the residual is not negative
      always_comb begin
         if (!z_cur[Z_W-1]) begin
            x_in = x_cur - y_sh;
            y_in = y_cur + x_sh;
            z_in = z_cur - ATAN;
         end else begin
            x_in = x_cur + y_sh;
            y_in = y_cur - x_sh;
            z_in = z_cur + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (en) begin
            ctl_ff[i] <= ctl_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            last_ff[i] <= last_cur;
            mag_ff[i]  <= mag_cur;
            ang_ff[i]  <= ang_cur;
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
         end
      end
   end

   function automatic logic signed [W-1:0] clamp(input logic signed [W+2:0] v);
      logic signed [W-1:0] r;
      if (v > (W+3)'(VMAX)) begin
         r = VMAX;
      end else if (v < (W+3)'(VMIN)) begin
         r = VMIN;
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

   logic signed [XW-1:0] x_sum, y_sum;
   logic signed [W+1:0]  x_rnd, y_rnd;
   logic signed [W+2:0]  x_sgn, y_sgn;
   logic signed [W-1:0]  re_in, im_in;
   logic                 valid_ff, last_out_ff;
   logic signed [W-1:0]  mag_out_ff, ang_out_ff, re_ff, im_ff;

   // round q28 to q16, undo the fold, clamp
   always_comb begin
      x_sum = x_ff[N-1] + RND;
      y_sum = y_ff[N-1] + RND;
      x_rnd = x_sum[XW-1:OUT_SHIFT];
      y_rnd = y_sum[XW-1:OUT_SHIFT];
      if (ctl_ff[N-1].neg) begin
         x_sgn = -((W+3)'(x_rnd));
         y_sgn = -((W+3)'(y_rnd));
      end else begin
         x_sgn = (W+3)'(x_rnd);
         y_sgn = (W+3)'(y_rnd);
      end
      re_in = clamp(x_sgn);
      im_in = clamp(y_sgn);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl_ff[N-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_out_ff <= last_ff[N-1];
         mag_out_ff  <= mag_ff[N-1];
         ang_out_ff  <= ang_ff[N-1];
         re_ff       <= re_in;
         im_ff       <= im_in;
      end
   end

   assign valid_o = valid_ff;
   assign last_o  = last_out_ff;
   assign mag_o   = mag_out_ff;
   assign ang_o   = ang_out_ff;
   assign re_o    = re_ff;
   assign im_o    = im_ff;

endmodule

@@ hw/rtl/bvcr_skid.sv @@
`include "bus_voltage_correct_and_rectify_assert.svh"

module bvcr_skid #(
   parameter int WIDTH = 4 * bvcr_pkg::VALUE_WIDTH_DEF + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             pipe_en,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import bvcr_pkg::*;

   logic             out_valid_ff, spare_valid_ff;
   logic [WIDTH-1:0] out_data_ff, spare_data_ff;
   logic             push, pop;

   // the pipeline moves whenever the spare slot is free
   assign pipe_en = !spare_valid_ff;
   assign push    = in_valid && pipe_en;
   assign pop     = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff   <= spare_valid_ff || push;
         spare_valid_ff <= 1'b0;
      end else if (push) begin
         spare_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_data_ff <= spare_valid_ff ? spare_data_ff : in_data;
      end else if (push) begin
         spare_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   `BVCR_ASSERT(a_spare_implies_out, clock, reset, spare_valid_ff |-> out_valid_ff)
   `BVCR_ASSERT(a_held_stays, clock, reset, out_valid_ff && !out_ready |=> out_valid_ff)
   `BVCR_ASSERT(a_spare_only_on_stall, clock, reset, $rose(spare_valid_ff) |-> $past(out_valid_ff && !out_ready))
   `BVCR_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !out_valid_ff && !spare_valid_ff)

endmodule
